// File: sv/bdpt_pkg.sv
// ============================================================================
// bdpt_pkg
// Shared types and constants for the button debounce press timer.
// ============================================================================
package bdpt_pkg;

  // Settle counter and debounce setting width
  localparam int unsigned SettleW = 16;
  // Width of the press duration on the result port
  localparam int unsigned DurOutW = 24;
  // Debounce setting after reset
  localparam logic [SettleW-1:0] DebounceReset = 16'd20;

  // Register file
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;
  localparam logic [0:0] RegDebounceTicks = 1'b0;

  // Debouncer phase codes
  localparam logic [1:0] PH_UP      = 2'd0;
  localparam logic [1:0] PH_FALLING = 2'd1;
  localparam logic [1:0] PH_DOWN    = 2'd2;
  localparam logic [1:0] PH_RISING  = 2'd3;

  // One result as produced by the core
  typedef struct packed {
    logic               debounced_pressed;
    logic               release_event;
    logic [DurOutW-1:0] press_duration;
    logic               led_on;
  } bdpt_result_t;

endpackage

// File: sv/button_debounce_press_timer_unit.sv
// Path: a sample passes through the input register, then the result
//   register, and its result is shown from there.
// Throughput: one sample per cycle; the only stall comes from out_stall_i.
// Reset: rst_ni clears the debouncer to up, all counters to zero, the
//   debounce setting to 20 and both pipeline valids.
// ============================================================================
// button_debounce_press_timer_unit
// Four-state button debouncer with press timer and LED pulse replay.
// ============================================================================
module button_debounce_press_timer_unit import bdpt_pkg::*; #(
  parameter int unsigned DURATION_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // sample channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               button_level_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               debounced_pressed_o,
  output logic               release_event_o,
  output logic [DurOutW-1:0] press_duration_o,
  output logic               led_on_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [PdataW-1:0]  pwdata,
  output logic [PdataW-1:0]  prdata,
  output logic               pready
);

  logic               s1_valid_q;
  logic               s1_level_q;
  logic               out_valid_q;
  bdpt_result_t       out_q;
  bdpt_result_t       result;
  logic               out_hold;
  logic               s1_adv;
  logic [SettleW-1:0] debounce_ticks;

  bdpt_cfg u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .debounce_ticks_o (debounce_ticks)
  );

  // Pipeline control
  assign out_hold   = out_valid_q && out_stall_i;
  assign s1_adv     = s1_valid_q && !out_hold;
  assign in_stall_o = s1_valid_q && out_hold;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_level_q <= button_level_i;
    end
  end

  bdpt_core #(
    .DurationBits (DURATION_BITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (s1_adv),
    .level_i          (s1_level_q),
    .debounce_ticks_i (debounce_ticks),
    .result_o         (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_hold) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= result;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign debounced_pressed_o = out_q.debounced_pressed;
  assign release_event_o     = out_q.release_event;
  assign press_duration_o    = out_q.press_duration;
  assign led_on_o            = out_q.led_on;

endmodule

// File: sv/bdpt_cfg.sv
// ============================================================================
// bdpt_cfg
// APB register file holding the debounce tick setting.
// ============================================================================
module bdpt_cfg import bdpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [PdataW-1:0]  pwdata,
  output logic [PdataW-1:0]  prdata,
  output logic               pready,
  output logic [SettleW-1:0] debounce_ticks_o
);

  logic [SettleW-1:0] debounce_ticks_q;
  logic               wr_en;
  logic               sel_debounce;

  assign pready       = 1'b1;
  assign sel_debounce = (paddr[PaddrW-1] == RegDebounceTicks);
  assign wr_en        = psel && penable && pwrite && sel_debounce;

  // Register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= DebounceReset;
    end else if (wr_en) begin
      debounce_ticks_q <= pwdata[SettleW-1:0];
    end
  end

  // Read back, unmapped offsets read zero
  assign prdata = sel_debounce ? PdataW'(debounce_ticks_q) : '0;

  assign debounce_ticks_o = debounce_ticks_q;

endmodule

// File: sv/bdpt_core.sv
// ============================================================================
// bdpt_core
// Debounce state machine, press timer and LED pulse with one held replay.
// ============================================================================
module bdpt_core import bdpt_pkg::*; #(
  parameter int unsigned DurationBits = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               level_i,
  input  logic [SettleW-1:0] debounce_ticks_i,
  output bdpt_result_t       result_o
);

  localparam int unsigned ExtW = (DurationBits > DurOutW) ? DurationBits : DurOutW;
  localparam logic [DurationBits-1:0] DurMax = {DurationBits{1'b1}};
  localparam logic [DurationBits-1:0] DurOne = DurationBits'(1);

  logic [1:0]              phase_q,  phase_d;
  logic [SettleW-1:0]      settle_q, settle_d;
  logic [DurationBits-1:0] press_q,  press_d;
  logic [DurationBits-1:0] last_q,   last_d;
  logic [DurationBits-1:0] pulse_q,  pulse_d;
  logic                    pend_q,   pend_d;

  logic [DurationBits-1:0] pulse_dec;
  logic [SettleW-1:0]      settle_inc;
  logic                    settle_ok;
  logic                    rel;
  logic [ExtW-1:0]         dur_ext;

  // Saturating settle increment and threshold check
  assign settle_inc = (settle_q != '1) ? settle_q + SettleW'(1) : settle_q;
  assign settle_ok  = (settle_inc >= debounce_ticks_i);
  assign pulse_dec  = (pulse_q != '0) ? pulse_q - DurOne : pulse_q;

  // Next state for one sample
  always_comb begin
    phase_d  = phase_q;
    settle_d = settle_q;
    press_d  = press_q;
    last_d   = last_q;
    pulse_d  = pulse_dec;
    pend_d   = pend_q;
    rel      = 1'b0;

    // replay held event once the pulse has run out
    if (pulse_dec == '0 && pend_q) begin
      pulse_d = last_q;
      pend_d  = 1'b0;
    end

    // press timer, saturating
    if ((phase_q == PH_DOWN || phase_q == PH_RISING) && press_q != DurMax) begin
      press_d = press_q + DurOne;
    end

    case (phase_q)
      PH_UP: begin
        if (!level_i) begin
          phase_d  = PH_FALLING;
          settle_d = '0;
        end
      end
      PH_FALLING: begin
        if (!level_i) begin
          settle_d = settle_inc;
          if (settle_ok) begin
            phase_d = PH_DOWN;
            press_d = '0;
          end
        end else begin
          phase_d = PH_UP;
        end
      end
      PH_DOWN: begin
        if (level_i) begin
          phase_d  = PH_RISING;
          settle_d = '0;
        end
      end
      PH_RISING: begin
        if (level_i) begin
          settle_d = settle_inc;
          if (settle_ok) begin
            phase_d = PH_UP;
            last_d  = press_d;
            rel     = 1'b1;
          end
        end else begin
          phase_d = PH_DOWN;
        end
      end
      default: begin
        phase_d = PH_UP;
      end
    endcase

    // confirmed release starts a pulse or is held
    if (rel) begin
      if (pulse_d == '0) begin
        pulse_d = last_d;
      end else begin
        pend_d = 1'b1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_UP;
      settle_q <= '0;
      press_q  <= '0;
      last_q   <= '0;
      pulse_q  <= '0;
      pend_q   <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      settle_q <= settle_d;
      press_q  <= press_d;
      last_q   <= last_d;
      pulse_q  <= pulse_d;
      pend_q   <= pend_d;
    end
  end

  // Result fields from the state after this sample
  assign dur_ext = ExtW'(last_d);

  always_comb begin
    result_o.debounced_pressed = (phase_d == PH_DOWN) || (phase_d == PH_RISING);
    result_o.release_event     = rel;
    result_o.press_duration    = dur_ext[DurOutW-1:0];
    result_o.led_on            = (pulse_d != '0);
  end

endmodule

// File: sv/bdpt_checker.sv
// ============================================================================
// bdpt_checker
// Port-level checks for the button debounce press timer.
// ============================================================================
module bdpt_checker import bdpt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               debounced_pressed_o,
  input logic               release_event_o,
  input logic [DurOutW-1:0] press_duration_o,
  input logic               led_on_o
);

  // a release leaves the debouncer in the released state
  a_rel_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && release_event_o |-> !debounced_pressed_o)
    else $error("release event while still pressed");

  // a release lights the LED unless the press was zero ticks long
  a_rel_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && release_event_o |-> led_on_o || press_duration_o == '0)
    else $error("release event without LED pulse");

  // input back-pressure only comes from a stalled waiting result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(press_duration_o)
      && $stable(release_event_o) && $stable(led_on_o))
    else $error("stalled result changed");

endmodule

bind button_debounce_press_timer_unit bdpt_checker u_bdpt_checker (.*);

// File: tb/tb_button_debounce_press_timer_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_button_debounce_press_timer_unit
// Self-checking bench for the button debouncer with press timer and LED
// pulse replay. Raw button samples go in as requests. A cycle-level
// predictor of the debouncer, the press timer and the pulse replay computes
// each result. A monitor compares every result field by field, in order.
// The bench covers the reset setting, bounces, the zero and maximum
// settings, held and collapsed release events, back-pressure and random
// press sequences.
// ============================================================================
module tb_button_debounce_press_timer_unit;
  import bdpt_pkg::*;

  localparam int unsigned DurBits = 24;
  localparam logic [DurBits-1:0] DurMax = '1;
  localparam logic [PaddrW-1:0] DebounceAddr = PaddrW'(4 * RegDebounceTicks);

  // DUT ports
  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               button_level_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               debounced_pressed_o;
  logic               release_event_o;
  logic [DurOutW-1:0] press_duration_o;
  logic               led_on_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PaddrW-1:0]  paddr;
  logic [PdataW-1:0]  pwdata;
  logic [PdataW-1:0]  prdata;
  logic               pready;

  button_debounce_press_timer_unit #(
    .DURATION_BITS(DurBits)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .button_level_i     (button_level_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .debounced_pressed_o(debounced_pressed_o),
    .release_event_o    (release_event_o),
    .press_duration_o   (press_duration_o),
    .led_on_o           (led_on_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // Predicted debouncer state
  logic [SettleW-1:0] debounce_cfg;
  logic [1:0]         phase;
  logic [SettleW-1:0] settle;
  logic [DurBits-1:0] press_ticks;
  logic [DurBits-1:0] last_dur;
  logic [DurBits-1:0] pulse_left;
  logic               held_event;

  bdpt_result_t pending_results[$];
  bdpt_result_t due;
  bdpt_result_t seen;

  int unsigned errors;
  int unsigned accepted;
  int unsigned burst_left;
  int unsigned hold_cycles;
  int unsigned stall_mode;
  int unsigned stall_tick;
  bit          gaps_on;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("tb_button_debounce_press_timer_unit: errors");
    $finish;
  end

  // One tick of the debouncer, timer and LED pulse; returns the result
  function automatic bdpt_result_t debounce_step(input logic lvl);
    bdpt_result_t r;
    logic         rel;
    rel = 1'b0;
    // pulse countdown, then replay of a held event
    if (pulse_left != '0) pulse_left = pulse_left - 1'b1;
    if (pulse_left == '0 && held_event) begin
      pulse_left = last_dur;
      held_event = 1'b0;
    end
    // press timer runs while the press is accepted
    if (phase == PH_DOWN || phase == PH_RISING) begin
      if (press_ticks != DurMax) press_ticks = press_ticks + 1'b1;
    end
    case (phase)
      PH_UP: begin
        if (!lvl) begin
          phase  = PH_FALLING;
          settle = '0;
        end
      end
      PH_FALLING: begin
        if (!lvl) begin
          if (settle != '1) settle = settle + 1'b1;
          if (settle >= debounce_cfg) begin
            phase       = PH_DOWN;
            press_ticks = '0;
          end
        end else begin
          phase = PH_UP;
        end
      end
      PH_DOWN: begin
        if (lvl) begin
          phase  = PH_RISING;
          settle = '0;
        end
      end
      default: begin
        if (lvl) begin
          if (settle != '1) settle = settle + 1'b1;
          if (settle >= debounce_cfg) begin
            phase    = PH_UP;
            last_dur = press_ticks;
            rel      = 1'b1;
          end
        end else begin
          phase = PH_DOWN;
        end
      end
    endcase
    // confirmed release starts a pulse or is held
    if (rel) begin
      if (pulse_left == '0) pulse_left = last_dur;
      else held_event = 1'b1;
    end
    r.debounced_pressed = (phase == PH_DOWN || phase == PH_RISING);
    r.release_event     = rel;
    r.press_duration    = last_dur[DurOutW-1:0];
    r.led_on            = (pulse_left != '0);
    return r;
  endfunction

  // Receiver stall pattern, with a counted hold-off on request
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 4) < 3);
        default: out_stall_i <= ((stall_tick % 11) < 4);
      endcase
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.debounced_pressed = debounced_pressed_o;
      seen.release_event     = release_event_o;
      seen.press_duration    = press_duration_o;
      seen.led_on            = led_on_o;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        due = pending_results.pop_front();
        if (seen.debounced_pressed !== due.debounced_pressed) begin
          $error("debounced_pressed: expected %0d, got %0d",
                 due.debounced_pressed, seen.debounced_pressed);
          errors++;
        end
        if (seen.release_event !== due.release_event) begin
          $error("release_event: expected %0d, got %0d",
                 due.release_event, seen.release_event);
          errors++;
        end
        if (seen.press_duration !== due.press_duration) begin
          $error("press_duration: expected %0d, got %0d",
                 due.press_duration, seen.press_duration);
          errors++;
        end
        if (seen.led_on !== due.led_on) begin
          $error("led_on: expected %0d, got %0d", due.led_on, seen.led_on);
          errors++;
        end
      end
    end
  end

  // Send one sample request; bursts with random gaps when enabled
  task automatic push_sample(input logic lvl);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 1) == 1) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    in_valid_i     <= 1'b1;
    button_level_i <= lvl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(debounce_step(lvl));
    accepted++;
  endtask

  task automatic push_run(input logic lvl, input int unsigned n);
    repeat (n) push_sample(lvl);
  endtask

  // Optional bounces, a held press, bounces on release, then idle level
  task automatic press_and_release(input int unsigned bounces,
                                   input int unsigned hold_ticks,
                                   input int unsigned idle_ticks);
    int unsigned bmax;
    bmax = (debounce_cfg < 2) ? 1 : ((debounce_cfg > 30) ? 30 : debounce_cfg);
    repeat (bounces) begin
      push_run(1'b0, $urandom_range(1, bmax));
      push_sample(1'b1);
    end
    push_run(1'b0, hold_ticks);
    repeat (bounces) begin
      push_run(1'b1, $urandom_range(1, bmax));
      push_sample(1'b0);
    end
    push_run(1'b1, idle_ticks);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Register write: setup then access cycle; only while idle
  task automatic write_debounce(input logic [SettleW-1:0] ticks);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DebounceAddr;
    pwdata  <= PdataW'(ticks);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    debounce_cfg = ticks;
    @(posedge clk_i);
    // read back through prdata
    if (prdata !== PdataW'(ticks)) begin
      $error("prdata: expected %0d, got %0d", ticks, prdata);
      errors++;
    end
  endtask

  // Press and release at the setting left by reset
  task automatic test_reset_setting();
    gaps_on    = 1'b0;
    stall_mode = 0;
    push_run(1'b1, 3);
    press_and_release(0, 26, 25);
    wait_drained();
  endtask

  // Bounces on both edges fall back to the stable state
  task automatic test_bounces();
    write_debounce(16'd3);
    gaps_on    = 1'b1;
    stall_mode = 1;
    push_run(1'b0, 2);
    push_run(1'b1, 2);
    push_run(1'b0, 3);
    push_sample(1'b1);
    push_run(1'b0, 10);
    push_run(1'b1, 3);
    push_run(1'b0, 2);
    push_run(1'b1, 6);
    wait_drained();
  endtask

  // Out-of-range zero setting acts like one
  task automatic test_zero_setting();
    write_debounce(16'd0);
    stall_mode = 3;
    push_sample(1'b1);
    push_run(1'b0, 2);
    push_run(1'b1, 2);
    push_sample(1'b0);
    push_sample(1'b1);
    push_run(1'b0, 3);
    push_sample(1'b1);
    push_sample(1'b0);
    push_run(1'b1, 4);
    wait_drained();
  endtask

  // Releases during a running pulse are held and collapse into one
  task automatic test_held_event();
    write_debounce(16'd1);
    stall_mode = 1;
    push_run(1'b0, 40);
    push_run(1'b1, 2);
    push_run(1'b0, 3);
    push_run(1'b1, 2);
    push_run(1'b0, 4);
    push_run(1'b1, 2);
    push_run(1'b1, 60);
    wait_drained();
  endtask

  // Long receiver hold-off fills the block, then a full drain pause
  task automatic test_backpressure();
    write_debounce(16'd2);
    gaps_on     = 1'b0;
    stall_mode  = 0;
    hold_cycles = 300;
    repeat (12) press_and_release($urandom_range(0, 1), $urandom_range(3, 8), 4);
    wait_drained();
    gaps_on    = 1'b1;
    stall_mode = 2;
    repeat (6) press_and_release(1, $urandom_range(3, 20), $urandom_range(1, 10));
    wait_drained();
  endtask

  // Random press sequences over several debounce settings
  task automatic test_random_sequences();
    int unsigned db;
    int unsigned pick;
    int unsigned stop_at;
    int unsigned extra;
    for (int p = 0; p < 8; p++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       db = 0;
        1:       db = $urandom_range(13, 60);
        default: db = $urandom_range(1, 8);
      endcase
      wait_drained();
      write_debounce(16'(db));
      stall_mode = $urandom_range(0, 3);
      gaps_on    = ($urandom_range(0, 3) != 0);
      stop_at    = accepted + 90;
      while (accepted < stop_at) begin
        if ($urandom_range(0, 4) != 0) begin
          // short presses after long ones land on a running pulse
          extra = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 4) : $urandom_range(5, 60);
          press_and_release($urandom_range(0, 2), db + 1 + extra,
                            $urandom_range(1, 2 * db + 20));
        end else begin
          repeat ($urandom_range(1, 12)) push_sample(1'($urandom_range(0, 1)));
        end
      end
    end
    wait_drained();
  endtask

  // Largest setting: short presses and releases are never accepted
  task automatic test_max_setting();
    write_debounce(16'hFFFF);
    gaps_on    = 1'b0;
    stall_mode = 0;
    push_run(1'b0, 60);
    push_run(1'b1, 4);
    push_run(1'b0, 30);
    push_run(1'b1, 5);
    wait_drained();
  endtask

  // Main sequence
  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    button_level_i <= 1'b1;
    out_stall_i    <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    errors       = 0;
    accepted     = 0;
    burst_left   = 0;
    hold_cycles  = 0;
    stall_mode   = 0;
    stall_tick   = 0;
    gaps_on      = 1'b0;
    debounce_cfg = DebounceReset;
    phase        = PH_UP;
    settle       = '0;
    press_ticks  = '0;
    last_dur     = '0;
    pulse_left   = '0;
    held_event   = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_setting();
    test_bounces();
    test_zero_setting();
    test_held_event();
    test_backpressure();
    test_random_sequences();
    test_max_setting();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_button_debounce_press_timer_unit: clean");
    end else begin
      $display("tb_button_debounce_press_timer_unit: errors");
    end
    $finish;
  end

endmodule

// File: button_debounce_press_timer_unit.f
sv/bdpt_pkg.sv
sv/bdpt_cfg.sv
sv/bdpt_core.sv
sv/button_debounce_press_timer_unit.sv
sv/bdpt_checker.sv
tb/tb_button_debounce_press_timer_unit.sv
